FILE: rtl/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
// Used by the channel interfaces, the list cell, the controller and the top level.
package stq_pkg;

	localparam int SLOTS  = 16;
	localparam int ID_W   = 4;
	localparam int OFF_W  = 16;
	localparam int TIME_W = 32;
	localparam int FUNC_W = 2;
	localparam int TPS_W  = 16;
	localparam int PROD_W = OFF_W + TPS_W;

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1024);
	localparam logic [OFF_W-1:0] ND_NONE   = '1;

	// Request operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ARM    = 2'd0,
		FUNC_CANCEL = 2'd1,
		FUNC_TICK   = 2'd2
	} func_t;

	// Broadcast operation applied by every cell of the chain
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_POP,
		CELL_INSERT,
		CELL_REBASE
	} cell_op_t;

	// One list position
	typedef struct packed {
		logic             used;
		logic [ID_W-1:0]  id;
		logic [OFF_W-1:0] off;
	} slot_t;

	localparam slot_t SLOT_EMPTY = '0;

	// Command to the chain; off carries the new offset for insert and the
	// elapsed time for rebase
	typedef struct packed {
		cell_op_t         op;
		logic [ID_W-1:0]  id;
		logic [OFF_W-1:0] off;
	} cell_cmd_t;

	// Status of the list head back to the controller
	typedef struct packed {
		logic             used;
		logic [ID_W-1:0]  id;
		logic [OFF_W-1:0] off;
		logic             lt;
		logic             tail_used;
	} head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_EXPIRE,
		ST_MUL,
		ST_SAT,
		ST_FINAL
	} state_t;

endpackage

FILE: rtl/stq_if.sv
// Request and response channel interfaces of the sorted timer queue.
// Depends on stq_pkg for the field widths.
interface stq_req_if;
	import stq_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   entry;
	logic [OFF_W-1:0]  delay;
	logic [TIME_W-1:0] now;

	modport source (output valid, func, entry, delay, now, input ready);
	modport sink   (input valid, func, entry, delay, now, output ready);
endinterface

interface stq_rsp_if;
	import stq_pkg::*;

	logic             valid;
	logic             ready;
	logic             expired_valid;
	logic [ID_W-1:0]  expired_entry;
	logic             wake;
	logic [OFF_W-1:0] next_delay;
	logic             last;

	modport source (output valid, expired_valid, expired_entry, wake, next_delay, last,
		input ready);
	modport sink   (input valid, expired_valid, expired_entry, wake, next_delay, last,
		output ready);
endinterface

FILE: rtl/stq_cell.sv
// One position of the sorted timer list: holds a slot and trades it with its neighbors.
// Depends on stq_pkg for slot_t and cell_cmd_t.
module stq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  stq_pkg::cell_cmd_t cmd,
	input  stq_pkg::slot_t     left,
	input  logic               left_lt,
	input  logic               shift_in,
	input  stq_pkg::slot_t     right,
	output stq_pkg::slot_t     slot,
	output logic               lt,
	output logic               shift_out
);
	import stq_pkg::*;

	slot_t slot_q;
	slot_t slot_d;
	logic  shifting;

	// Flag positions ahead of the insert point and the start of a removal
	assign lt        = slot_q.used && (slot_q.off < cmd.off);
	assign shifting  = shift_in ||
		((cmd.op == CELL_REMOVE) && slot_q.used && (slot_q.id == cmd.id));
	assign shift_out = shifting;
	assign slot      = slot_q;

	// Pick the next content of this position
	always_comb begin
		slot_d = slot_q;
		case (cmd.op)
			CELL_REMOVE, CELL_POP: begin
				if (shifting) slot_d = right;
			end
			CELL_INSERT: begin
				if (!lt) begin
					if (left_lt) begin
						slot_d.used = 1'b1;
						slot_d.id   = cmd.id;
						slot_d.off  = cmd.off;
					end else begin
						slot_d = left;
					end
				end
			end
			CELL_REBASE: begin
				if (slot_q.used) slot_d.off = slot_q.off - cmd.off;
			end
			default: slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_EMPTY;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule

FILE: rtl/stq_ctrl.sv
// Sequencer of the sorted timer queue: takes requests, drives the cell chain,
// scales the next wake delay and holds the response register. Depends on stq_pkg
// and the channel interfaces.
module stq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	stq_req_if.sink                  req,
	stq_rsp_if.source                rsp,
	input  logic [stq_pkg::TPS_W-1:0] tps,
	input  stq_pkg::head_t           head,
	output stq_pkg::cell_cmd_t       cmd
);
	import stq_pkg::*;

	state_t              state_q, state_d;
	logic [FUNC_W-1:0]   func_q;
	logic [ID_W-1:0]     id_q;
	logic [OFF_W-1:0]    del_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   ts_q;
	logic [TIME_W-1:0]   set_time_q;
	logic                exp_any_q;
	logic                wake_q;
	logic [OFF_W-1:0]    nd_q;
	logic [PROD_W-1:0]   prod_q;

	logic                rsp_valid_q;
	logic                rsp_exp_q;
	logic [ID_W-1:0]     rsp_entry_q;
	logic                rsp_wake_q;
	logic [OFF_W-1:0]    rsp_nd_q;
	logic                rsp_last_q;

	logic                out_free;
	logic                accept;
	logic                head_due;
	logic                emit_exp;
	logic                emit_fin;
	logic                do_rebase;
	logic                first_arm;
	logic [OFF_W-1:0]    diff;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;
	assign head_due = head.used && ({{(TIME_W-OFF_W){1'b0}}, head.off} <= ts_q);
	assign diff     = head.off - ts_q[OFF_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.func == FUNC_ARM || req.func == FUNC_CANCEL) state_d = ST_REMOVE;
					else if (req.func == FUNC_TICK) state_d = ST_EXPIRE;
					else state_d = ST_FINAL;
				end
			end
			ST_REMOVE: state_d = (func_q == FUNC_ARM) ? ST_INSERT : ST_FINAL;
			ST_INSERT: state_d = ST_FINAL;
			ST_EXPIRE: begin
				if (!head_due) state_d = head.used ? ST_MUL : ST_FINAL;
			end
			ST_MUL:    state_d = ST_SAT;
			ST_SAT:    state_d = ST_FINAL;
			ST_FINAL: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs: chain command and response strobes
	always_comb begin
		req.ready = 1'b0;
		cmd       = '{op: CELL_HOLD, id: id_q, off: '0};
		emit_exp  = 1'b0;
		emit_fin  = 1'b0;
		do_rebase = 1'b0;
		first_arm = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_REMOVE: cmd.op = CELL_REMOVE;
			ST_INSERT: begin
				if (!head.used) begin
					cmd.op    = CELL_INSERT;
					cmd.off   = del_q;
					first_arm = 1'b1;
				end else if (!head.tail_used) begin
					cmd.op  = CELL_INSERT;
					cmd.off = del_q + ts_q[OFF_W-1:0];
				end
			end
			ST_EXPIRE: begin
				if (head_due) begin
					if (out_free) begin
						emit_exp = 1'b1;
						cmd.op   = CELL_POP;
					end
				end else if (head.used && exp_any_q) begin
					do_rebase = 1'b1;
					cmd.op    = CELL_REBASE;
					cmd.off   = ts_q[OFF_W-1:0];
				end
			end
			ST_FINAL:  emit_fin = out_free;
			default:   req.ready = 1'b0;
		endcase
	end

	// Control state and time base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			set_time_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (first_arm || do_rebase) set_time_q <= now_q;
			if (emit_exp || emit_fin) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// Request fields, working values and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= req.func;
			id_q      <= req.entry;
			del_q     <= req.delay;
			now_q     <= req.now;
			ts_q      <= req.now - set_time_q;
			exp_any_q <= 1'b0;
			wake_q    <= 1'b0;
			nd_q      <= '0;
		end
		if (state_q == ST_INSERT) wake_q <= !head.lt && (!head.used || !head.tail_used);
		if (emit_exp) exp_any_q <= 1'b1;
		if (state_q == ST_EXPIRE && !head_due && !head.used) nd_q <= ND_NONE;
		if (do_rebase) ts_q <= '0;
		if (state_q == ST_MUL) prod_q <= diff * tps;
		if (state_q == ST_SAT) nd_q <= (|prod_q[PROD_W-1:OFF_W]) ? ND_NONE : prod_q[OFF_W-1:0];

		// Load one transaction into the response register
		if (emit_exp) begin
			rsp_exp_q   <= 1'b1;
			rsp_entry_q <= head.id;
			rsp_wake_q  <= 1'b0;
			rsp_nd_q    <= '0;
			rsp_last_q  <= 1'b0;
		end else if (emit_fin) begin
			rsp_exp_q   <= 1'b0;
			rsp_entry_q <= '0;
			rsp_wake_q  <= wake_q;
			rsp_nd_q    <= nd_q;
			rsp_last_q  <= 1'b1;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.expired_valid = rsp_exp_q;
	assign rsp.expired_entry = rsp_entry_q;
	assign rsp.wake          = rsp_wake_q;
	assign rsp.next_delay    = rsp_nd_q;
	assign rsp.last          = rsp_last_q;

endmodule

FILE: rtl/sorted_timer_queue.sv
// Sorted timer queue top level: the chain of list cells, the sequencer and the
// jiffy rate register. Depends on stq_pkg, the channel interfaces, stq_cell and stq_ctrl.
//
// Keeps up to 16 armed timers, one per entry id, in a row of cells sorted by
// deadline; every cell compares and shifts in the same cycle, whatever the
// position of a removal or an insertion. One request is handled at a time. An
// arm goes through accept, remove, insert and result, a cancel skips insert and
// an unused code goes from accept to result. A tick is accepted, pops one
// expired entry per cycle while the response register is free (each one a
// response transaction), finds the head not expired, then multiplies the
// remaining seconds by ticks_per_second, saturates and gives the final
// response; with an empty list it finishes right after the scan. The response
// register lets a finished result wait while the next request is taken; a
// stalled response stalls the expiry scan. ticks_per_second resets to 1024 and
// is to be written only while the queue is idle; the block does not enforce it.
module sorted_timer_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	stq_req_if.sink                   req,
	stq_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [stq_pkg::TPS_W-1:0] cfg_wdata
);
	import stq_pkg::*;

	logic [TPS_W-1:0] tps_q;
	cell_cmd_t        cmd;
	head_t            head;
	slot_t            slots    [SLOTS];
	slot_t            left_s   [SLOTS];
	slot_t            right_s  [SLOTS];
	logic [SLOTS-1:0] lt_vec;
	logic [SLOTS-1:0] sh_vec;
	logic [SLOTS-1:0] left_lt;
	logic [SLOTS-1:0] sh_in;
	logic [SLOTS-1:0] used_vec;
	logic [SLOTS-2:0] order_ok;

	// Hold the jiffy rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_we) begin
			tps_q <= cfg_wdata;
		end
	end

	// Wire the chain: head cell sees an open insert point and starts a pop
	for (genvar g = 0; g < SLOTS; g++) begin : g_chain
		if (g == 0) begin : g_first
			assign left_s[g]  = SLOT_EMPTY;
			assign left_lt[g] = 1'b1;
			assign sh_in[g]   = (cmd.op == CELL_POP);
		end else begin : g_mid
			assign left_s[g]  = slots[g-1];
			assign left_lt[g] = lt_vec[g-1];
			assign sh_in[g]   = sh_vec[g-1];
		end
		if (g == SLOTS-1) begin : g_last
			assign right_s[g] = SLOT_EMPTY;
		end else begin : g_inner
			assign right_s[g] = slots[g+1];
		end

		stq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left      (left_s[g]),
			.left_lt   (left_lt[g]),
			.shift_in  (sh_in[g]),
			.right     (right_s[g]),
			.slot      (slots[g]),
			.lt        (lt_vec[g]),
			.shift_out (sh_vec[g])
		);

		assign used_vec[g] = slots[g].used;
	end

	// Report the head and the fill state
	assign head.used      = slots[0].used;
	assign head.id        = slots[0].id;
	assign head.off       = slots[0].off;
	assign head.lt        = lt_vec[0];
	assign head.tail_used = slots[SLOTS-1].used;

	stq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.tps    (tps_q),
		.head   (head),
		.cmd    (cmd)
	);

	// Neighbor order of the list
	for (genvar g = 0; g < SLOTS-1; g++) begin : g_order
		assign order_ok[g] = !slots[g+1].used || (slots[g].off <= slots[g+1].off);
	end

	// Used positions stay packed from the head
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(used_vec & (used_vec + 1'b1)) == '0)
		else $error("timer list has a gap");

	// Offsets stay sorted
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n) &order_ok)
		else $error("timer list out of order");

	// Only expiry transactions come before the final one
	a_exp_first: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.expired_valid)
		else $error("non-final response without expiry");

	// The sequencer is busy in the cycle after it takes a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for sorted_timer_queue: directed, rate-register and random tests.
// Depends on stq_pkg, the stq_req_if / stq_rsp_if interfaces and the sorted_timer_queue RTL.
`timescale 1ns / 100ps

module testbench;
	import stq_pkg::*;

	// The one operation code that the package leaves unnamed
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic             expired_valid;
		logic [ID_W-1:0]  expired_entry;
		logic             wake;
		logic [OFF_W-1:0] next_delay;
		logic             last;
	} timer_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [TPS_W-1:0] cfg_wdata;

	stq_req_if req_ch ();
	stq_rsp_if rsp_ch ();

	sorted_timer_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the timer list, kept sorted and packed from position 0
	logic [ID_W-1:0]   tq_id   [SLOTS];
	logic [OFF_W-1:0]  tq_off  [SLOTS];
	int                tq_count;
	logic [TIME_W-1:0] tq_base;
	logic [TPS_W-1:0]  tq_rate;

	timer_result_t pending_results[$];

	bit req_idle_on;
	bit rsp_idle_on;
	int n_errors;
	int n_requests;
	int n_responses;
	int n_expiries;
	int n_rate_writes;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic void push_result(logic ev, logic [ID_W-1:0] ee, logic wk,
			logic [OFF_W-1:0] nd, logic ls);
		pending_results.push_back('{ev, ee, wk, nd, ls});
	endfunction

	// Close the gap at one list position
	function automatic void drop_at(int pos);
		int i;
		for (i = pos; i < tq_count - 1; i++) begin
			tq_id[i]  = tq_id[i + 1];
			tq_off[i] = tq_off[i + 1];
		end
		tq_count--;
		tq_id[tq_count]  = '0;
		tq_off[tq_count] = '0;
	endfunction

	function automatic void drop_entry(logic [ID_W-1:0] id);
		int i;
		for (i = 0; i < tq_count; i++) begin
			if (tq_id[i] == id) begin
				drop_at(i);
				return;
			end
		end
	endfunction

	// Apply one request to the shadow list and queue the responses it causes
	function automatic void predict_timers(logic [FUNC_W-1:0] func, logic [ID_W-1:0] entry,
			logic [OFF_W-1:0] delay, logic [TIME_W-1:0] now);
		logic [OFF_W-1:0]  off;
		logic [TIME_W-1:0] elapsed;
		logic [47:0]       jiffies;
		int                pos;
		int                i;
		logic              wake;
		case (func)
			FUNC_ARM: begin
				drop_entry(entry);
				wake = 1'b0;
				if (tq_count == 0) begin
					tq_id[0]  = entry;
					tq_off[0] = delay;
					tq_count  = 1;
					tq_base   = now;
					wake      = 1'b1;
				end else if (tq_count < SLOTS) begin
					// Rebase onto the stored set time, wrapping at 16 bits
					off = delay + OFF_W'(now - tq_base);
					pos = 0;
					while (pos < tq_count && tq_off[pos] < off)
						pos++;
					for (i = tq_count; i > pos; i--) begin
						tq_id[i]  = tq_id[i - 1];
						tq_off[i] = tq_off[i - 1];
					end
					tq_id[pos]  = entry;
					tq_off[pos] = off;
					tq_count++;
					wake = (pos == 0);
				end
				push_result(1'b0, '0, wake, '0, 1'b1);
			end
			FUNC_CANCEL: begin
				drop_entry(entry);
				push_result(1'b0, '0, 1'b0, '0, 1'b1);
			end
			FUNC_TICK: begin
				if (tq_count == 0) begin
					push_result(1'b0, '0, 1'b0, ND_NONE, 1'b1);
				end else begin
					elapsed = now - tq_base;
					if (elapsed >= TIME_W'(tq_off[0])) begin
						// Pop every expired head in list order
						while (tq_count > 0 && TIME_W'(tq_off[0]) <= elapsed) begin
							push_result(1'b1, tq_id[0], 1'b0, '0, 1'b0);
							n_expiries++;
							drop_at(0);
						end
						if (tq_count > 0) begin
							tq_base = now;
							for (i = 0; i < tq_count; i++)
								tq_off[i] = tq_off[i] - elapsed[OFF_W-1:0];
							elapsed = '0;
						end
					end
					if (tq_count == 0) begin
						push_result(1'b0, '0, 1'b0, ND_NONE, 1'b1);
					end else begin
						jiffies = (48'(tq_off[0]) - 48'(elapsed)) * 48'(tq_rate);
						push_result(1'b0, '0, 1'b0,
							(jiffies > 48'hFFFF) ? ND_NONE : jiffies[OFF_W-1:0], 1'b1);
					end
				end
			end
			default: push_result(1'b0, '0, 1'b0, '0, 1'b1);
		endcase
	endfunction

	// Drive one request transaction and predict it once accepted
	task automatic send_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] entry,
			logic [OFF_W-1:0] delay, logic [TIME_W-1:0] now);
		int gap;
		gap = req_idle_on ? $urandom_range(0, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= func;
		req_ch.entry <= entry;
		req_ch.delay <= delay;
		req_ch.now   <= now;
		do @(posedge clk); while (!req_ch.ready);
		predict_timers(func, entry, delay, now);
		n_requests++;
	endtask

	// Hold requests until every predicted response has arrived
	task automatic wait_for_drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_rate(logic [TPS_W-1:0] value);
		wait_for_drain();
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we  <= 1'b0;
		tq_rate  = value;
		n_rate_writes++;
	endtask

	// Response side: when pacing is on, stall a random number of cycles before each transaction
	initial begin : rsp_pacing
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rsp_idle_on ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Compare each response transaction with the oldest prediction
	always @(posedge clk) begin : check_responses
		timer_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("response with no request pending");
			end else begin
				want = pending_results.pop_front();
				n_responses++;
				if (rsp_ch.expired_valid !== want.expired_valid)
					report_mismatch($sformatf("expired_valid got %b want %b",
						rsp_ch.expired_valid, want.expired_valid));
				if (rsp_ch.expired_entry !== want.expired_entry)
					report_mismatch($sformatf("expired_entry got %0d want %0d",
						rsp_ch.expired_entry, want.expired_entry));
				if (rsp_ch.wake !== want.wake)
					report_mismatch($sformatf("wake got %b want %b",
						rsp_ch.wake, want.wake));
				if (rsp_ch.next_delay !== want.next_delay)
					report_mismatch($sformatf("next_delay got %0d want %0d",
						rsp_ch.next_delay, want.next_delay));
				if (rsp_ch.last !== want.last)
					report_mismatch($sformatf("last got %b want %b",
						rsp_ch.last, want.last));
			end
		end
	end

	// Corner cases of arm, cancel, tick and the unused code at the reset rate
	task automatic test_directed();
		int e;
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd100);
		send_request(FUNC_ARM, 4'd0, 16'd0, 32'd0);
		// offset wraps at 16 bits
		send_request(FUNC_ARM, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
		// equal deadline goes ahead of the head
		send_request(FUNC_ARM, 4'd5, 16'd0, 32'd0);
		send_request(FUNC_CANCEL, 4'd9, 16'd0, 32'd0);
		send_request(FUNC_CANCEL, 4'd0, 16'd0, 32'd0);
		send_request(FUNC_SPARE, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd1);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd15);
		// fill every slot with tied deadlines, then re-arm one of them
		for (e = 0; e < SLOTS; e++)
			send_request(FUNC_ARM, ID_W'(e), 16'(e % 4), 32'd1000);
		send_request(FUNC_ARM, 4'd7, 16'd2, 32'd1000);
		// expire the whole list in one tick
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd71000);
	endtask

	// Zero, lowest and highest rates, with saturation of next_delay
	task automatic test_rate_extremes();
		set_rate(16'd0);
		send_request(FUNC_ARM, 4'd3, 16'd100, 32'd5000);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd5000);
		set_rate(16'hFFFF);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd5001);
		send_request(FUNC_ARM, 4'd4, 16'd0, 32'd5001);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd5001);
		set_rate(16'd1);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd5050);
		send_request(FUNC_CANCEL, 4'd3, 16'd0, 32'd5050);
		send_request(FUNC_TICK, 4'd0, 16'd0, 32'd5050);
	endtask

	// Random traffic on an advancing seconds clock, in phases of varied rate and pacing
	task automatic test_random();
		int                seg;
		int                i;
		int                pick;
		logic [TIME_W-1:0] clock_s;
		logic [TPS_W-1:0]  rate;
		clock_s = $urandom;
		for (seg = 0; seg < 8; seg++) begin
			case ($urandom_range(0, 3))
				0: rate = 16'd1;
				1: rate = 16'hFFFF;
				2: rate = TPS_W'($urandom_range(1, 200));
				default: rate = TPS_W'($urandom_range(1, 65535));
			endcase
			set_rate(rate);
			req_idle_on = (seg % 4 == 0) || (seg % 4 == 2);
			rsp_idle_on = (seg % 4 == 0) || (seg % 4 == 3);
			for (i = 0; i < 50; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					send_request(FUNC_W'($urandom_range(0, 3)), ID_W'($urandom),
						OFF_W'($urandom), $urandom);
				else if (pick < 40)
					send_request(FUNC_ARM, ID_W'($urandom), OFF_W'($urandom_range(0, 60)),
						clock_s);
				else if (pick < 48)
					send_request(FUNC_ARM, ID_W'($urandom), OFF_W'($urandom), clock_s);
				else if (pick < 60)
					send_request(FUNC_CANCEL, ID_W'($urandom), OFF_W'($urandom), clock_s);
				else if (pick < 95) begin
					clock_s = clock_s + $urandom_range(0, 30);
					send_request(FUNC_TICK, ID_W'($urandom), OFF_W'($urandom), clock_s);
				end else
					send_request(FUNC_SPARE, ID_W'($urandom), OFF_W'($urandom), clock_s);
				// now and then let the queue run dry mid-phase
				if ($urandom_range(0, 39) == 0)
					wait_for_drain();
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req_ch.valid = 1'b0;
		req_ch.func  = '0;
		req_ch.entry = '0;
		req_ch.delay = '0;
		req_ch.now   = '0;
		tq_count     = 0;
		tq_base      = '0;
		tq_rate      = TPS_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			tq_id[i]  = '0;
			tq_off[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_rate_extremes();
		test_random();

		wait_for_drain();
		repeat (20) @(posedge clk);
		$display("run covered %0d requests, %0d responses, %0d expiries, %0d rate writes",
			n_requests, n_responses, n_expiries, n_rate_writes);
		if (n_errors == 0)
			$display("sorted_timer_queue: match");
		else
			$display("sorted_timer_queue: mismatch");
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("timeout with %0d responses pending", pending_results.size());
		$display("sorted_timer_queue: mismatch");
		$finish;
	end

endmodule

FILE: files.f
rtl/stq_pkg.sv
rtl/stq_if.sv
rtl/stq_cell.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_queue.sv
dv/testbench.sv
